@@ hdl/tpgd_pkg.sv @@
`default_nettype none
package tpgd_pkg;

    // defaults for the top-level parameters
    localparam int DEF_FIFO_DEPTH   = 256;
    localparam int DEF_MAX_DEQUEUE  = 63;
    localparam int DEF_NUM_CHANNELS = 4;

    localparam int LEN_W   = 14;
    localparam int GRANT_W = 24;
    localparam int BYTES_W = 25;
    localparam int CHAN_W  = 2;
    localparam int MODE_W  = 2;
    localparam int KIND_W  = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    localparam logic [GRANT_W-1:0] LIMIT_RESET = 24'd1048576;
    localparam logic [BYTES_W-1:0] REQ_MAX     = 25'h1FFFFFF;

    // power modes; the spare code behaves as sleep
    localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DOZE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLEEP  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
    localparam logic ACTION_ARRIVAL = 1'b0;
    localparam logic ACTION_GATE    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ARRIVAL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PACKET  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPORT  = 2'd2;

    // one input word after unpacking
    typedef struct packed {
        logic               action;
        logic               priority_req;
        logic [LEN_W-1:0]   pkt_len;
        logic [GRANT_W-1:0] grant_bytes;
        logic [CHAN_W-1:0]  gate_channel;
        logic [MODE_W-1:0]  energy_mode;
    } item_t;

    // one result word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               out_priority;
        logic [LEN_W-1:0]   out_len;
        logic               accepted;
        logic [BYTES_W-1:0] request_bytes;
        logic               report_formal;
        logic               tuning;
        logic [CHAN_W-1:0]  out_channel;
        logic               wake_request;
        logic               last;
    } result_t;

    // handshake between the front queue and the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_REPORT
    } state_t;

endpackage
`default_nettype wire

@@ hdl/tpgd_front.sv @@
`default_nettype none
module tpgd_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tpgd_pkg::item_t in_item,
    output tpgd_pkg::queue_out_t q_out,
    input  wire logic           q_pop
);
    import tpgd_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    // two-word queue between accept and execute
    assign in_ready = (count_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign pop  = q_pop && (count_reg != 2'd0);
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload store
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

@@ hdl/tpgd_back.sv @@
`default_nettype none
module tpgd_back #(
    parameter int FIFO_DEPTH   = tpgd_pkg::DEF_FIFO_DEPTH,
    parameter int MAX_DEQUEUE  = tpgd_pkg::DEF_MAX_DEQUEUE,
    parameter int NUM_CHANNELS = tpgd_pkg::DEF_NUM_CHANNELS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire tpgd_pkg::queue_out_t        q_in,
    output logic                             q_pop,
    input  wire logic                        cfg_we,
    input  wire logic [tpgd_pkg::GRANT_W-1:0] cfg_limit,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output tpgd_pkg::result_t                res
);
    import tpgd_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int NW = $clog2(MAX_DEQUEUE + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);
    localparam logic [NW-1:0] N_MAX    = NW'(MAX_DEQUEUE);

    logic [LEN_W-1:0] high_mem [FIFO_DEPTH];
    logic [LEN_W-1:0] low_mem  [FIFO_DEPTH];

    state_t             state_reg, state_next;
    logic [AW-1:0]      high_head_reg, high_head_next, high_tail_reg, high_tail_next;
    logic [AW-1:0]      low_head_reg, low_head_next, low_tail_reg, low_tail_next;
    logic [CW-1:0]      high_count_reg, high_count_next, low_count_reg, low_count_next;
    logic [BYTES_W-1:0] high_bytes_reg, high_bytes_next, low_bytes_reg, low_bytes_next;
    logic [CHAN_W-1:0]  chan_reg, chan_next;
    logic [31:0]        tuning_total_reg, tuning_total_next;
    logic [GRANT_W-1:0] limit_reg;
    logic [GRANT_W-1:0] grant_reg, grant_next;
    logic [BYTES_W-1:0] used_reg, used_next;
    logic [BYTES_W-1:0] req_reg, req_next;
    logic               tune_reg, tune_next;
    logic               active_reg, active_next;
    logic [NW-1:0]      n_reg, n_next;
    logic               sel_high_reg, sel_high_next;
    logic [LEN_W-1:0]   hi_rd_reg, lo_rd_reg;
    logic               res_valid_reg;
    result_t            res_reg, res_next;

    logic               out_ready, load_out, rd_en, wr_high, wr_low;
    item_t              it;
    logic [CHAN_W-1:0]  chan_mod;
    logic [BYTES_W:0]   total;
    logic [GRANT_W-1:0] grant_c;
    logic [BYTES_W:0]   req_wide;
    logic [LEN_W-1:0]   plen;
    logic [BYTES_W-1:0] used_sum;
    logic               high_ok, low_ok;

    assign out_ready = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign it = q_in.item;
    // the channel field is two bits, so one subtraction folds it into range
    assign chan_mod = (NUM_CHANNELS <= 1) ? '0
                    : (32'(it.gate_channel) >= NUM_CHANNELS)
                      ? CHAN_W'(32'(it.gate_channel) - NUM_CHANNELS) : it.gate_channel;
    assign total = {1'b0, high_bytes_reg} + {1'b0, low_bytes_reg};
    assign grant_c = ({2'b0, it.grant_bytes} > total) ? total[GRANT_W-1:0] : it.grant_bytes;
    assign req_wide = total - {2'b0, grant_c};
    assign plen = sel_high_reg ? hi_rd_reg : lo_rd_reg;
    assign used_sum = used_reg + BYTES_W'(plen);
    assign high_ok = (high_bytes_reg < {1'b0, limit_reg}) && (high_count_reg != CNT_FULL);
    assign low_ok  = (low_bytes_reg < {1'b0, limit_reg}) && (low_count_reg != CNT_FULL);

    // sequencer: arrivals in one step, gates as read / check rounds in active mode, then report
    always_comb begin
        state_next        = state_reg;
        high_head_next    = high_head_reg;
        high_tail_next    = high_tail_reg;
        low_head_next     = low_head_reg;
        low_tail_next     = low_tail_reg;
        high_count_next   = high_count_reg;
        low_count_next    = low_count_reg;
        high_bytes_next   = high_bytes_reg;
        low_bytes_next    = low_bytes_reg;
        chan_next         = chan_reg;
        tuning_total_next = tuning_total_reg;
        grant_next        = grant_reg;
        used_next         = used_reg;
        req_next          = req_reg;
        tune_next         = tune_reg;
        active_next       = active_reg;
        n_next            = n_reg;
        sel_high_next     = sel_high_reg;
        res_next          = '0;
        res_next.out_channel = chan_reg;
        q_pop    = 1'b0;
        load_out = 1'b0;
        rd_en    = 1'b0;
        wr_high  = 1'b0;
        wr_low   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_in.valid) begin
                    if (it.action == ACTION_ARRIVAL) begin
                        if (out_ready) begin
                            q_pop = 1'b1;
                            load_out = 1'b1;
                            res_next.kind = KIND_ARRIVAL;
                            res_next.out_priority = it.priority_req;
                            res_next.out_len = it.pkt_len;
                            res_next.last = 1'b1;
                            if (!it.priority_req && high_ok) begin
                                wr_high = 1'b1;
                                res_next.accepted = 1'b1;
                                high_tail_next = (high_tail_reg == PTR_LAST) ? '0
                                                 : high_tail_reg + 1'b1;
                                high_count_next = high_count_reg + 1'b1;
                                high_bytes_next = high_bytes_reg + BYTES_W'(it.pkt_len);
                            end else if (it.priority_req && low_ok) begin
                                wr_low = 1'b1;
                                res_next.accepted = 1'b1;
                                low_tail_next = (low_tail_reg == PTR_LAST) ? '0
                                                : low_tail_reg + 1'b1;
                                low_count_next = low_count_reg + 1'b1;
                                low_bytes_next = low_bytes_reg + BYTES_W'(it.pkt_len);
                            end
                            res_next.wake_request = (it.energy_mode != MODE_ACTIVE)
                                                    && (high_count_next != '0);
                        end
                    end else begin
                        q_pop = 1'b1;
                        tune_next = (chan_mod != chan_reg);
                        chan_next = chan_mod;
                        if (chan_mod != chan_reg) begin
                            tuning_total_next = tuning_total_reg + 32'd1;
                        end
                        grant_next = grant_c;
                        req_next = req_wide[BYTES_W] ? REQ_MAX : req_wide[BYTES_W-1:0];
                        active_next = (it.energy_mode == MODE_ACTIVE);
                        used_next = '0;
                        n_next = '0;
                        state_next = (it.energy_mode == MODE_ACTIVE) ? ST_READ : ST_REPORT;
                    end
                end
            end
            ST_READ: begin
                if (n_reg == N_MAX || (high_count_reg == '0 && low_count_reg == '0)) begin
                    state_next = ST_REPORT;
                end else begin
                    rd_en = 1'b1;
                    sel_high_next = (high_count_reg != '0);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (used_sum > BYTES_W'(grant_reg)) begin
                    state_next = ST_REPORT;
                end else if (out_ready) begin
                    load_out = 1'b1;
                    res_next.kind = KIND_PACKET;
                    res_next.out_priority = !sel_high_reg;
                    res_next.out_len = plen;
                    res_next.tuning = tune_reg;
                    used_next = used_sum;
                    n_next = n_reg + 1'b1;
                    if (sel_high_reg) begin
                        high_head_next = (high_head_reg == PTR_LAST) ? '0
                                         : high_head_reg + 1'b1;
                        high_count_next = high_count_reg - 1'b1;
                        high_bytes_next = (high_bytes_reg >= BYTES_W'(plen))
                                          ? high_bytes_reg - BYTES_W'(plen) : '0;
                    end else begin
                        low_head_next = (low_head_reg == PTR_LAST) ? '0
                                        : low_head_reg + 1'b1;
                        low_count_next = low_count_reg - 1'b1;
                        low_bytes_next = (low_bytes_reg >= BYTES_W'(plen))
                                         ? low_bytes_reg - BYTES_W'(plen) : '0;
                    end
                    state_next = ST_READ;
                end
            end
            ST_REPORT: begin
                if (out_ready) begin
                    load_out = 1'b1;
                    res_next.kind = KIND_REPORT;
                    res_next.request_bytes = req_reg;
                    res_next.report_formal = active_reg;
                    res_next.tuning = tune_reg;
                    res_next.wake_request = !active_reg && (high_count_reg != '0);
                    res_next.last = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and queue state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            high_head_reg    <= '0;
            high_tail_reg    <= '0;
            low_head_reg     <= '0;
            low_tail_reg     <= '0;
            high_count_reg   <= '0;
            low_count_reg    <= '0;
            high_bytes_reg   <= '0;
            low_bytes_reg    <= '0;
            chan_reg         <= '0;
            tuning_total_reg <= '0;
            limit_reg        <= LIMIT_RESET;
            res_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            high_head_reg    <= high_head_next;
            high_tail_reg    <= high_tail_next;
            low_head_reg     <= low_head_next;
            low_tail_reg     <= low_tail_next;
            high_count_reg   <= high_count_next;
            low_count_reg    <= low_count_next;
            high_bytes_reg   <= high_bytes_next;
            low_bytes_reg    <= low_bytes_next;
            chan_reg         <= chan_next;
            tuning_total_reg <= tuning_total_next;
            if (cfg_we) begin
                limit_reg <= cfg_limit;
            end
            if (load_out) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // per-gate working registers and output word
    always_ff @(posedge aclk) begin
        grant_reg    <= grant_next;
        used_reg     <= used_next;
        req_reg      <= req_next;
        tune_reg     <= tune_next;
        active_reg   <= active_next;
        n_reg        <= n_next;
        sel_high_reg <= sel_high_next;
        if (load_out) begin
            res_reg <= res_next;
        end
    end

    // packet length stores
    always_ff @(posedge aclk) begin
        if (wr_high) begin
            high_mem[high_tail_reg] <= it.pkt_len;
        end
        if (wr_low) begin
            low_mem[low_tail_reg] <= it.pkt_len;
        end
        if (rd_en) begin
            hi_rd_reg <= high_mem[high_head_reg];
            lo_rd_reg <= low_mem[low_head_reg];
        end
    end

    a_high_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        high_count_reg <= CNT_FULL) else $error("high queue count beyond depth");
    a_low_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        low_count_reg <= CNT_FULL) else $error("low queue count beyond depth");
    a_high_empty_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        high_count_reg == '0 |-> high_bytes_reg == '0)
        else $error("empty high queue holds bytes");
    a_dequeue_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CHECK |-> n_reg < N_MAX)
        else $error("dequeue beyond cap");
    a_tuning_on_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        tuning_total_reg != $past(tuning_total_reg) |-> $past(state_reg == ST_IDLE && q_pop)
        ) else $error("tuning count moved outside a gate");

endmodule
`default_nettype wire

@@ hdl/two_priority_grant_dequeue.sv @@
`default_nettype none
// Two-priority upstream queue. Arrival words (tuser 0) are admitted into the high or low
// length queue and answered with one status word. A gate word (tuser 1) retunes the
// channel if needed, then in active mode drains packets in strict priority while they fit
// the grant (at most MAX_DEQUEUE), and ends with a report word; tlast marks the final
// word of each input. An arrival is handled in the idle state of the back end, where a
// gate is also started; each dequeued packet then takes a registered read of the length
// store, then the fit check; the drain stops when the queues are empty, the cap is
// reached or the head packet does not fit, and is followed by the report; outside
// active mode a gate goes straight from start to report. A two-word input queue and an
// output register let both sides stall independently. buffer_limit is written over
// cfg_valid/cfg_data.
module two_priority_grant_dequeue #(
    parameter int FIFO_DEPTH   = tpgd_pkg::DEF_FIFO_DEPTH,
    parameter int MAX_DEQUEUE  = tpgd_pkg::DEF_MAX_DEQUEUE,
    parameter int NUM_CHANNELS = tpgd_pkg::DEF_NUM_CHANNELS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // priority_req, pkt_len, grant_bytes, gate_channel, energy_mode, zero pad
    input  wire logic [tpgd_pkg::S_DATA_W-1:0] s_tdata,
    // action
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_priority, out_len, accepted, request_bytes, report_formal, tuning,
    // out_channel, wake_request, zero pad
    output logic [tpgd_pkg::M_DATA_W-1:0]      m_tdata,
    // kind
    output logic [tpgd_pkg::KIND_W-1:0]        m_tuser,
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tpgd_pkg::GRANT_W-1:0]  cfg_data
);
    import tpgd_pkg::*;

    item_t      in_item;
    queue_out_t q_out;
    logic       q_pop;
    result_t    res;

    // unpack the input word
    assign in_item.action       = s_tuser;
    assign in_item.priority_req = s_tdata[0];
    assign in_item.pkt_len      = s_tdata[14:1];
    assign in_item.grant_bytes  = s_tdata[38:15];
    assign in_item.gate_channel = s_tdata[40:39];
    assign in_item.energy_mode  = s_tdata[42:41];

    assign cfg_ready = 1'b1;

    tpgd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_out    (q_out),
        .q_pop    (q_pop)
    );

    tpgd_back #(
        .FIFO_DEPTH   (FIFO_DEPTH),
        .MAX_DEQUEUE  (MAX_DEQUEUE),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_in      (q_out),
        .q_pop     (q_pop),
        .cfg_we    (cfg_valid),
        .cfg_limit (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // pack the result word
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {2'b00, res.wake_request, res.out_channel, res.tuning,
                      res.report_formal, res.request_bytes, res.accepted,
                      res.out_len, res.out_priority};

endmodule
`default_nettype wire
